[hw/rtl/assert_macros.svh]
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/rmth_pkg.sv]
`timescale 1ns / 1ps
package rmth_pkg;

   localparam int SAMPLE_W = 32;
   localparam int MEDIAN_W = 33;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REPLACE
   } chain_op_type;

   // command broadcast to every cell of one chain
   typedef struct packed {
      chain_op_type                op;
      logic signed [SAMPLE_W-1:0]  value;
   } chain_ctrl_type;

   // what a cell sees of its two neighbors, and its own flag as rep_left
   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  left_value;
      logic signed [SAMPLE_W-1:0]  right_value;
      logic                        ins_left;
      logic                        rep_left;
      logic                        right_flag;
   } cell_link_type;

   typedef enum logic {
      ST_IDLE,
      ST_WORK
   } state_type;

endpackage

[hw/rtl/running_median_two_heaps.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// channel   direction  ports                                              beat when
// req       in         req_valid req_stall req_sample                     valid && !stall
// rsp       out        rsp_valid rsp_stall rsp_median_halves              valid && !stall
//                      rsp_stored_count rsp_dropped
//
// a beat: the accepting edge updates the cell chains, each with at most one
// broadcast insert or replace in every cell, and the work state then forms the
// median from the two chain heads into the output register once it is free
// reset (synchronous, high) empties both halves; cell contents are left as they are
// the block takes the next req beat while a result waits; a held rsp stall only
// keeps the following beat in its work cycle until the output register frees
module running_median_two_heaps #(
   parameter int HALF_CAPACITY = 512
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  logic signed [rmth_pkg::SAMPLE_W-1:0]         req_sample,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output logic signed [rmth_pkg::MEDIAN_W-1:0]         rsp_median_halves,
   output logic [$clog2(2*HALF_CAPACITY+1)-1:0]         rsp_stored_count,
   output logic                                         rsp_dropped
);
   import rmth_pkg::*;

   localparam int CW = $clog2(HALF_CAPACITY + 1);
   localparam int TW = $clog2(2 * HALF_CAPACITY + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(HALF_CAPACITY);

   state_type state_ff, state_in;

   logic [CW-1:0] lower_count_ff, lower_count_in;
   logic [CW-1:0] upper_count_ff, upper_count_in;
   logic          dropped_ff, dropped_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [MEDIAN_W-1:0] median_ff, median_in;
   logic [TW-1:0]              total_ff, total_in;
   logic                       rsp_dropped_ff, rsp_dropped_in;

   chain_ctrl_type             lower_ctrl, upper_ctrl;
   logic signed [SAMPLE_W-1:0] lower_top, upper_top;

   logic          req_fire;
   logic          store_full;
   logic [TW-1:0] total_now;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign store_full = (lower_count_ff == FULL_COUNT) && (upper_count_ff == FULL_COUNT);
   assign total_now  = TW'(lower_count_ff) + TW'(upper_count_ff);

   // lower half: descending chain, its head is the max
   rmth_chain #(
      .DEPTH (HALF_CAPACITY)
   ) u_lower (
      .clock      (clock),
      .ctrl       (lower_ctrl),
      .descending (1'b1),
      .count      (lower_count_ff),
      .top_value  (lower_top)
   );

   // upper half: ascending chain, its head is the min
   rmth_chain #(
      .DEPTH (HALF_CAPACITY)
   ) u_upper (
      .clock      (clock),
      .ctrl       (upper_ctrl),
      .descending (1'b0),
      .count      (upper_count_ff),
      .top_value  (upper_top)
   );

   // route the sample through one half and push the displaced extreme into the other; a full store drops the sample
   always_comb begin
      lower_ctrl.op    = OP_HOLD;
      lower_ctrl.value = req_sample;
      upper_ctrl.op    = OP_HOLD;
      upper_ctrl.value = req_sample;
      lower_count_in   = lower_count_ff;
      upper_count_in   = upper_count_ff;
      dropped_in       = dropped_ff;
      if (req_fire) begin
         dropped_in = store_full;
         if (store_full) begin
            // full store: sample discarded, halves unchanged
         end else if (lower_count_ff == upper_count_ff) begin
            // even count: the larger of sample and lower max goes up
            if ((lower_count_ff != '0) && (lower_top > req_sample)) begin
               lower_ctrl.op    = OP_REPLACE;
               upper_ctrl.value = lower_top;
            end
            upper_ctrl.op  = OP_INSERT;
            upper_count_in = upper_count_ff + 1'b1;
         end else begin
            // odd count: the smaller of sample and upper min goes down
            if (upper_top < req_sample) begin
               upper_ctrl.op    = OP_REPLACE;
               lower_ctrl.value = upper_top;
            end
            lower_ctrl.op  = OP_INSERT;
            lower_count_in = lower_count_ff + 1'b1;
         end
      end
   end

   // sequencer and output register
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      median_in      = median_ff;
      total_in       = total_ff;
      rsp_dropped_in = rsp_dropped_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            // chains have settled; load once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               total_in       = total_now;
               rsp_dropped_in = dropped_ff;
               if (upper_count_ff > lower_count_ff) begin
                  median_in = {upper_top, 1'b0};
               end else if (upper_count_ff != '0) begin
                  median_in = {lower_top[SAMPLE_W-1], lower_top} +
                              {upper_top[SAMPLE_W-1], upper_top};
               end else begin
                  median_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         lower_count_ff <= '0;
         upper_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         lower_count_ff <= lower_count_in;
         upper_count_ff <= upper_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dropped_ff     <= dropped_in;
      median_ff      <= median_in;
      total_ff       <= total_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_median_halves = median_ff;
   assign rsp_stored_count  = total_ff;
   assign rsp_dropped       = rsp_dropped_ff;

   // upper half holds the same count or one more
   `ASSERT_IMPLY(a_balance, clock, reset, 1'b1, (upper_count_ff == lower_count_ff) || (upper_count_ff == lower_count_ff + 1'b1))
   // an accepted beat always moves the sequencer into its work cycle
   `ASSERT_NEXT(a_fire_work, clock, reset, req_fire, state_ff == ST_WORK)
   // an accepted sample into a store with room grows it by one
   `ASSERT_NEXT(a_grow, clock, reset, req_fire && !store_full, total_now == $past(total_now) + 1'b1)
   // a dropped flag is only shown while the store is full
   `ASSERT_IMPLY(a_drop_full, clock, reset, rsp_valid && rsp_dropped, store_full)

endmodule

[hw/rtl/rmth_cell.sv]
`timescale 1ns / 1ps
module rmth_cell (
   input  logic                             clock,
   input  rmth_pkg::chain_ctrl_type         ctrl,
   input  logic                             descending,
   input  logic                             occupied,
   input  rmth_pkg::cell_link_type          link,
   output logic signed [rmth_pkg::SAMPLE_W-1:0] value,
   output logic                             flag
);
   import rmth_pkg::*;

   logic signed [SAMPLE_W-1:0] value_ff;
   logic signed [SAMPLE_W-1:0] value_in;

   // incoming value belongs at or before this slot
   assign flag  = !occupied ||
                  (descending ? (ctrl.value > value_ff) : (ctrl.value < value_ff));
   assign value = value_ff;

   always_comb begin
      case (ctrl.op)
         OP_INSERT:  value_in = flag ? (link.ins_left ? link.left_value : ctrl.value)
                                     : value_ff;
         OP_REPLACE: value_in = link.right_flag ? (link.rep_left ? value_ff : ctrl.value)
                                                : link.right_value;
         default:    value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[hw/rtl/rmth_chain.sv]
`timescale 1ns / 1ps
module rmth_chain #(
   parameter int DEPTH = 512
) (
   input  logic                                 clock,
   input  rmth_pkg::chain_ctrl_type             ctrl,
   input  logic                                 descending,
   input  logic [$clog2(DEPTH+1)-1:0]           count,
   output logic signed [rmth_pkg::SAMPLE_W-1:0] top_value
);
   import rmth_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic signed [SAMPLE_W-1:0] val  [DEPTH];
   logic                       flag [DEPTH];
   cell_link_type              link [DEPTH];
   logic                       occ  [DEPTH];

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         assign occ[g] = count > CW'(g);

         if (g == 0) begin : g_head
            assign link[g].left_value = val[g];
            assign link[g].ins_left   = 1'b0;
            assign link[g].rep_left   = 1'b0;
         end else begin : g_body
            assign link[g].left_value = val[g-1];
            assign link[g].ins_left   = flag[g-1];
            assign link[g].rep_left   = flag[g];
         end

         if (g == DEPTH - 1) begin : g_tail
            assign link[g].right_value = val[g];
            assign link[g].right_flag  = 1'b1;
         end else begin : g_mid
            assign link[g].right_value = val[g+1];
            assign link[g].right_flag  = flag[g+1];
         end

         rmth_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .descending (descending),
            .occupied   (occ[g]),
            .link       (link[g]),
            .value      (val[g]),
            .flag       (flag[g])
         );
      end
   endgenerate

   assign top_value = val[0];

endmodule
